FILE: design/sotrc_pkg.sv
// Shared types and constants for the sorted offset table with range collapse.
package sotrc_pkg;

  // Offsets are deadlines reduced modulo 1024, a power of two, so the
  // reduction keeps the low bits of the deadline.
  localparam int unsigned OFFSET_W   = 10;
  localparam int unsigned DEADLINE_W = 32;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned COUNT_W    = 7;

  // The read path selects within groups of eight cells first.
  localparam int unsigned GRP   = 8;
  localparam int unsigned GRP_W = 3;

  typedef logic [OFFSET_W-1:0] offset_t;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_INSERT  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_READ    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_REVERSED = 2'd2,
    STAT_NOT_HELD = 2'd3
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic    ins;
    logic    rep;
    offset_t value;
    offset_t lo;
    offset_t hi;
  } cell_cmd_t;

endpackage

FILE: design/sotrc_cell.sv
// One cell of the sorted chain: holds a single offset and hands it to its neighbour.
module sotrc_cell
  import sotrc_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      held_i,
  input  offset_t   prev_val_i,
  input  logic      prev_keep_i,
  output offset_t   val_o,
  output logic      keep_o
);

  offset_t val_q, val_d;

  // A held entry not above the new offset stays where it is; the kept cells
  // form a prefix of the chain.
  assign keep_o = held_i && (val_q <= cmd_i.value);
  assign val_o  = val_q;

  always_comb begin
    val_d = val_q;
    if (cmd_i.ins) begin
      if (keep_o) begin
        val_d = val_q;
      end else if (prev_keep_i) begin
        val_d = cmd_i.value;
      end else begin
        val_d = prev_val_i;
      end
    end else if (cmd_i.rep) begin
      if ((cmd_i.lo < val_q) && (val_q < cmd_i.hi)) begin
        val_d = cmd_i.lo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_d_hold: val_q <= val_d;
  end

endmodule

FILE: design/sotrc_rdgrp.sv
// Registered eight-way selection of one cell value within a group.
module sotrc_rdgrp
  import sotrc_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  offset_t          vals_i [GRP],
  input  logic [GRP_W-1:0] sel_i,
  output offset_t          val_o
);

  offset_t val_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= vals_i[sel_i];
    end
  end

  assign val_o = val_q;

endmodule

FILE: design/sorted_offset_table_range_collapse.sv
// Top level of the sorted offset table: cell chain, read selection and result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | input     | in_valid_i/in_stall_o | action, deadline, range_low/high, index
//  out     | output    | out_valid_o/out_stall_i | entry_value, entry_count, status
//
// Clear, insert and replace complete at the accepting edge: every cell updates there
// and the result beat is registered at that same edge.
// A read passes through the two registered levels of the read selection
// (eight cells within a group, then one group); no beat is accepted in between.
// Reset clears the entry count, the read state and the result valid; the cell
// contents are not reset, as no entry at or beyond the count is ever read.
// A result waiting on a stalled output holds the input stalled until it is taken.
module sorted_offset_table_range_collapse
  import sotrc_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [DEADLINE_W-1:0] deadline_i,
  input  logic [OFFSET_W-1:0]   range_low_i,
  input  logic [OFFSET_W-1:0]   range_high_i,
  input  logic [IDX_W-1:0]      entry_index_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OFFSET_W-1:0]   entry_value_o,
  output logic [COUNT_W-1:0]    entry_count_o,
  output logic [1:0]            status_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned MW   = (CW > IDX_W) ? CW : IDX_W;
  localparam int unsigned NG   = (CAPACITY + GRP - 1) / GRP;
  localparam int unsigned GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int unsigned NC   = NG * GRP;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } rd_state_e;

  rd_state_e st_q, st_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          accept;
  logic          full;
  logic          reversed;
  logic          held_idx;
  logic          rd_ok_q;
  cell_cmd_t     cmd;

  offset_t cell_val  [NC];
  logic    cell_keep [CAPACITY];
  offset_t grp_val   [NG];

  logic [IDX_W+GW-1:0] idx_ext;
  logic [GW-1:0]       grp_sel;

  logic          out_valid_q;
  offset_t       out_value_q;
  logic [CW-1:0] out_count_q;
  status_e       out_status_q;
  logic          out_load;

  // Stall while a read finishes or while an unread result is held back.
  assign in_stall_o = (st_q == S_READ) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign full     = (cnt_q >= CW'(CAPACITY));
  assign reversed = (range_low_i > range_high_i);
  assign held_idx = (MW'(entry_index_i) < MW'(cnt_q));

  // An empty replace range needs no special handling: no offset lies strictly
  // between the bounds, so the cell compare changes nothing.
  assign cmd.ins   = accept && (action_i == ACT_INSERT) && !full;
  assign cmd.rep   = accept && (action_i == ACT_REPLACE) && !reversed;
  assign cmd.value = deadline_i[OFFSET_W-1:0];
  assign cmd.lo    = range_low_i;
  assign cmd.hi    = range_high_i;

  // The chain: cell zero sees a kept neighbour so that it takes the new
  // offset when nothing is kept ahead of it.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic    held;
    offset_t prev_val;
    logic    prev_keep;

    assign held = (MW'(cnt_q) > MW'(k));

    if (k == 0) begin : g_first
      assign prev_val  = '0;
      assign prev_keep = 1'b1;
    end else begin : g_rest
      assign prev_val  = cell_val[k-1];
      assign prev_keep = cell_keep[k-1];
    end

    sotrc_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .held_i     (held),
      .prev_val_i (prev_val),
      .prev_keep_i(prev_keep),
      .val_o      (cell_val[k]),
      .keep_o     (cell_keep[k])
    );
  end

  // Cells that pad the last group read as zero and are never selected.
  for (genvar k = CAPACITY; k < NC; k++) begin : g_pad
    assign cell_val[k] = '0;
  end

  // First read level: one value per group, registered at the accepting edge.
  for (genvar g = 0; g < NG; g++) begin : g_grp
    offset_t vals [GRP];
    for (genvar j = 0; j < GRP; j++) begin : g_tap
      assign vals[j] = cell_val[g*GRP + j];
    end

    sotrc_rdgrp u_rdgrp (
      .clk_i (clk_i),
      .en_i  (accept && (action_i == ACT_READ)),
      .vals_i(vals),
      .sel_i (entry_index_i[GRP_W-1:0]),
      .val_o (grp_val[g])
    );
  end

  // The group number is held in the read-state register path below.
  logic [GW-1:0] grp_sel_q;
  assign idx_ext = (IDX_W+GW)'(entry_index_i);
  assign grp_sel = idx_ext[GRP_W +: GW];

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      case (action_i)
        ACT_CLEAR:  cnt_d = '0;
        ACT_INSERT: if (!full) cnt_d = cnt_q + CW'(1);
        default:    cnt_d = cnt_q;
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      S_IDLE: if (accept && (action_i == ACT_READ)) st_d = S_READ;
      S_READ: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      st_q  <= S_IDLE;
    end else begin
      cnt_q <= cnt_d;
      st_q  <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (action_i == ACT_READ)) begin
      grp_sel_q <= grp_sel;
      rd_ok_q   <= held_idx;
    end
  end

  // Result register: non-read actions load at their accepting edge, a read
  // loads at the following edge from the second selection level.
  assign out_load = (accept && (action_i != ACT_READ)) || (st_q == S_READ);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_READ) begin
      out_value_q  <= rd_ok_q ? grp_val[grp_sel_q] : '0;
      out_count_q  <= cnt_q;
      out_status_q <= rd_ok_q ? STAT_OK : STAT_NOT_HELD;
    end else if (out_load) begin
      out_value_q  <= '0;
      out_count_q  <= cnt_d;
      if ((action_i == ACT_INSERT) && full) begin
        out_status_q <= STAT_FULL;
      end else if ((action_i == ACT_REPLACE) && reversed) begin
        out_status_q <= STAT_REVERSED;
      end else begin
        out_status_q <= STAT_OK;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_value_o = out_value_q;
  assign entry_count_o = COUNT_W'(out_count_q);
  assign status_o      = out_status_q;

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A read in flight delivers its beat at the next edge and frees the input.
  a_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_READ) |=> (out_valid_q && (st_q == S_IDLE)))
    else $error("read result not delivered");

  // No beat is taken while a read is being finished.
  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_READ) |-> in_stall_o)
    else $error("input accepted during read");

  // A clear empties the table.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (action_i == ACT_CLEAR)) |=> (cnt_q == '0))
    else $error("clear left entries held");

  // An accepted insert into a table with room grows the count by one.
  a_insert_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("insert did not add an entry");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sorted offset table with range collapse.
module testbench;
  import sotrc_pkg::*;

  // The table depth matches the block's default capacity. Offsets are taken
  // modulo 1024, so an offset is simply the low ten bits of a deadline.
  localparam int unsigned TABLE_DEPTH     = 64;
  localparam int unsigned RANDOM_ITEMS    = 1250;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  // One beat on the input channel, and one expected beat on the output channel.
  typedef struct packed {
    action_e                act;
    logic [DEADLINE_W-1:0]  deadline;
    offset_t                lo;
    offset_t                hi;
    logic [IDX_W-1:0]       idx;
  } action_beat_t;

  typedef struct packed {
    offset_t                value;
    logic [COUNT_W-1:0]     count;
    status_e                status;
  } table_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  in_valid_i    = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            action_i      = ACT_CLEAR;
  logic [DEADLINE_W-1:0] deadline_i    = '0;
  logic [OFFSET_W-1:0]   range_low_i   = '0;
  logic [OFFSET_W-1:0]   range_high_i  = '0;
  logic [IDX_W-1:0]      entry_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i   = 1'b0;
  logic [OFFSET_W-1:0]   entry_value_o;
  logic [COUNT_W-1:0]    entry_count_o;
  logic [1:0]            status_o;

  sorted_offset_table_range_collapse #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .deadline_i   (deadline_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .entry_index_i(entry_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .entry_value_o(entry_value_o),
    .entry_count_o(entry_count_o),
    .status_o     (status_o)
  );

  // Beats waiting to be offered, and results that the table should produce.
  action_beat_t  pending_beats[$];
  table_result_t expected_results[$];

  // Shadow copy of the table, advanced once per accepted input beat.
  offset_t     shadow_offsets [TABLE_DEPTH];
  int unsigned shadow_count = 0;

  // Rough count of entries as the stimulus is planned; it steers reads towards
  // held positions.
  int unsigned planned_count = 0;
  offset_t     last_offset   = '0;

  int unsigned total_items = 0;
  int unsigned beats_in    = 0;
  int unsigned mismatches  = 0;
  int unsigned cycles      = 0;
  logic        in_taken    = 1'b0;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Works out the result of one action and updates the shadow table. Inserts
  // shift larger entries up by one place, so equal offsets keep their arrival
  // order, which cannot be observed anyway.
  function automatic table_result_t predict_table_action(input action_beat_t b);
    table_result_t r;
    int unsigned   pos;
    offset_t       v;
    r.value  = '0;
    r.status = STAT_OK;
    case (b.act)
      ACT_CLEAR: begin
        shadow_count = 0;
      end
      ACT_INSERT: begin
        if (shadow_count >= TABLE_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          v   = b.deadline[OFFSET_W-1:0];
          pos = shadow_count;
          while (pos > 0 && shadow_offsets[pos-1] > v) begin
            shadow_offsets[pos] = shadow_offsets[pos-1];
            pos--;
          end
          shadow_offsets[pos] = v;
          shadow_count++;
        end
      end
      ACT_REPLACE: begin
        // An open range with nothing inside it leaves the table alone.
        if (b.lo > b.hi) begin
          r.status = STAT_REVERSED;
        end else if (int'(b.hi) > int'(b.lo) + 1) begin
          for (int unsigned k = 0; k < shadow_count; k++) begin
            if (shadow_offsets[k] > b.lo && shadow_offsets[k] < b.hi) begin
              shadow_offsets[k] = b.lo;
            end
          end
        end
      end
      default: begin
        if (b.idx < shadow_count) begin
          r.value = shadow_offsets[b.idx];
        end else begin
          r.status = STAT_NOT_HELD;
        end
      end
    endcase
    r.count = shadow_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic add_beat(input action_e a, input logic [DEADLINE_W-1:0] d, input int lo,
                          input int hi, input int idx);
    action_beat_t b;
    b.act      = a;
    b.deadline = d;
    b.lo       = lo[OFFSET_W-1:0];
    b.hi       = hi[OFFSET_W-1:0];
    b.idx      = idx[IDX_W-1:0];
    pending_beats.push_back(b);
    if (a == ACT_CLEAR) begin
      planned_count = 0;
    end else if (a == ACT_INSERT && planned_count < TABLE_DEPTH) begin
      planned_count++;
    end
  endtask

  // Fields that an action does not use are still randomised so that their
  // bits toggle as well.
  task automatic add_insert();
    logic [DEADLINE_W-1:0] d;
    d = $urandom;
    // Now and then repeat an earlier offset with different upper bits.
    if ($urandom_range(0, 7) == 0) begin
      d[OFFSET_W-1:0] = last_offset;
    end
    last_offset = d[OFFSET_W-1:0];
    add_beat(ACT_INSERT, d, $urandom, $urandom, $urandom);
  endtask

  task automatic add_read();
    int idx;
    if (planned_count != 0 && $urandom_range(0, 99) < 80) begin
      idx = $urandom_range(0, planned_count - 1);
    end else begin
      idx = $urandom_range(0, 63);
    end
    add_beat(ACT_READ, $urandom, $urandom, $urandom, idx);
  endtask

  task automatic add_replace();
    int lo;
    int hi;
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(1, 1023);
        hi = $urandom_range(0, lo - 1);
      end
      1: begin
        lo = $urandom_range(0, 1023);
        hi = lo;
      end
      2: begin
        lo = $urandom_range(0, 1022);
        hi = lo + 1;
      end
      default: begin
        lo = $urandom_range(0, 1021);
        hi = lo + $urandom_range(2, 1023 - lo);
      end
    endcase
    add_beat(ACT_REPLACE, $urandom, lo, hi, $urandom);
  endtask

  // Idling follows three phases: the sender idles more lightly than the
  // receiver, then the other way round, then neither idles at all.
  function automatic int unsigned sender_idle_pct();
    if (beats_in < total_items / 3) return 24;
    if (beats_in < 2 * total_items / 3) return 48;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (beats_in < total_items / 3) return 48;
    if (beats_in < 2 * total_items / 3) return 24;
    return 0;
  endfunction

  // Driver: a new beat is offered only once the previous one has been taken,
  // so a stalled beat stays on the inputs unchanged.
  always @(negedge clk_i) begin : driver
    action_beat_t b;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
        b = pending_beats.pop_front();
        action_i      <= b.act;
        deadline_i    <= b.deadline;
        range_low_i   <= b.lo;
        range_high_i  <= b.hi;
        entry_index_i <= b.idx;
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall. Once, early in the first phase, the receiver holds off for
  // a long stretch while the sender keeps offering beats, so that the result
  // register fills and the block has to stall its input.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && beats_in >= total_items / 6) begin
      hold_done   <= 1'b1;
      hold_left   <= HOLD_OFF_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < receiver_idle_pct());
    end
  end

  // Monitor: the output beat is checked before any input beat of the same edge
  // is predicted, because a result always leaves at a later edge than the one
  // at which its action was taken.
  always @(posedge clk_i) begin : monitor
    table_result_t want;
    action_beat_t  b;
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (entry_value_o !== want.value) begin
            report_mismatch("entry_value", entry_value_o, want.value);
          end
          if (entry_count_o !== want.count) begin
            report_mismatch("entry_count", entry_count_o, want.count);
          end
          if (status_o !== want.status) begin
            report_mismatch("status", status_o, want.status);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        b.act      = action_e'(action_i);
        b.deadline = deadline_i;
        b.lo       = range_low_i;
        b.hi       = range_high_i;
        b.idx      = entry_index_i;
        expected_results.push_back(predict_table_action(b));
        beats_in <= beats_in + 1;
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** sorted_offset_table_range_collapse: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned episode;
    int unsigned steps;
    int unsigned pick;
    int unsigned directed_n;

    // Directed opening: empty-table corner cases, the extreme deadlines, equal
    // offsets, every replace case and reads on either side of the held count.
    add_beat(ACT_READ, 32'h0, 0, 0, 0);
    add_beat(ACT_REPLACE, 32'h0, 5, 3, 0);
    add_beat(ACT_INSERT, 32'hFFFF_FFFF, 0, 0, 0);
    add_beat(ACT_INSERT, 32'h0000_0000, 0, 0, 0);
    add_beat(ACT_INSERT, 32'h0000_0400, 0, 0, 0);
    add_beat(ACT_INSERT, 32'hAAAA_A955, 0, 0, 0);
    add_beat(ACT_INSERT, 32'h5555_56AA, 0, 0, 0);
    add_beat(ACT_INSERT, 32'h8000_02AA, 0, 0, 0);
    add_beat(ACT_READ, 32'h0, 0, 0, 0);
    add_beat(ACT_READ, 32'h0, 0, 0, 5);
    add_beat(ACT_READ, 32'h0, 0, 0, 6);
    add_beat(ACT_READ, 32'h0, 0, 0, 63);
    add_beat(ACT_REPLACE, 32'h0, 100, 100, 0);
    add_beat(ACT_REPLACE, 32'h0, 340, 341, 0);
    add_beat(ACT_REPLACE, 32'h0, 1023, 0, 0);
    add_beat(ACT_REPLACE, 32'h0, 0, 1023, 0);
    add_beat(ACT_READ, 32'h0, 0, 0, 3);
    add_beat(ACT_REPLACE, 32'h0, 1022, 1023, 0);
    add_beat(ACT_READ, 32'h0, 0, 0, 5);
    add_beat(ACT_CLEAR, 32'h0, 0, 0, 0);
    add_beat(ACT_READ, 32'h0, 0, 0, 0);
    add_beat(ACT_INSERT, 32'h8000_0200, 0, 0, 0);
    directed_n = pending_beats.size();

    // Random part in episodes. Most start from a cleared table; some keep the
    // old contents so inserts build on them. Every fourth episode fills the
    // table past capacity so that full inserts and the top index are reached.
    episode = 0;
    while (pending_beats.size() < directed_n + RANDOM_ITEMS) begin
      episode++;
      if ($urandom_range(0, 4) != 0) begin
        add_beat(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
      end
      if (episode % 4 == 1) begin
        repeat (TABLE_DEPTH + 4) add_insert();
        add_beat(ACT_READ, $urandom, $urandom, $urandom, 63);
      end
      steps = $urandom_range(10, 50);
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          add_insert();
        end else if (pick < 65) begin
          add_replace();
        end else if (pick < 97) begin
          add_read();
        end else begin
          add_beat(ACT_CLEAR, $urandom, $urandom, $urandom, $urandom);
        end
      end
    end
    total_items = pending_beats.size();

    // Reset is released at a falling edge, clear of the block's clock edge.
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in < total_items) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** sorted_offset_table_range_collapse: PASSED **");
    end else begin
      $display("** sorted_offset_table_range_collapse: FAILED **");
    end
    $finish;
  end

endmodule
